/* design/cia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg: types and constants for the checked integer ALU
// Operation and status codes, beat payload structs and pipeline stage layout.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int DATA_WIDTH = 32;

    // stage numbering: prep, multiply, multiply check, one stage per
    // quotient bit, output register
    localparam int STG_PREP = 0;
    localparam int STG_MUL  = 1;
    localparam int STG_DIV0 = 2;
    localparam int STG_OUT  = DATA_WIDTH + 3;
    localparam int NUM_STG  = DATA_WIDTH + 4;

    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] POS_MAX  = SIGN_BIT - DATA_WIDTH'(1);

    typedef enum logic [3:0] {
        FN_ADD = 4'd0,
        FN_SUB = 4'd1,
        FN_MUL = 4'd2,
        FN_DIV = 4'd3,
        FN_MOD = 4'd4,
        FN_NEG = 4'd5,
        FN_AND = 4'd6,
        FN_OR  = 4'd7,
        FN_XOR = 4'd8,
        FN_NOT = 4'd9,
        FN_LT  = 4'd10,
        FN_GT  = 4'd11,
        FN_EQ  = 4'd12,
        FN_NE  = 4'd13
    } alu_func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]                   func;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } alu_req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        status_t                      status;
    } alu_rsp_t;

    // one pipeline stage; quo starts as |a| and shifts into the quotient
    typedef struct packed {
        logic [3:0]            func;
        logic                  na;
        logic                  nb;
        logic [DATA_WIDTH-1:0] mb;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] res;
        status_t               st;
    } alu_stage_t;

endpackage

/* design/checked_integer_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_integer_alu: pipelined signed ALU with overflow and div-by-zero check
// Add, sub, mul, truncating div/mod, neg, logic ops and compares on signed
// words; any error forces a zero result and reports it in status.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload               | direction
//  --------+----------------------+-----------------------+----------
//  req     | req_valid/req_ready  | func, operand_a/b     | in
//  rsp     | rsp_valid/rsp_ready  | result_value, status  | out
//
// Every operation passes through every stage; the pipe holds DATA_WIDTH + 4
// beats, and one beat may enter each cycle while req_ready is high. The
// length is set by the restoring divider, one quotient bit per stage.
// Each stage holds one beat and a valid bit; a stage loads when it is empty
// or when the stage after it moves, so bubbles close up under backpressure
// and a stall drops or repeats nothing.
// Reset clears only the valid bits; payload registers are left as is.
// ----------------------------------------------------------------------------
module checked_integer_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cia_pkg::alu_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cia_pkg::alu_rsp_t rsp
);
    import cia_pkg::*;

    // ------------------------------------------------------------------
    // Handshake: per-stage valid and a ready chain from the output back
    // ------------------------------------------------------------------
    logic [NUM_STG-1:0] v_reg;
    logic [NUM_STG:0]   rdy;

    assign rdy[NUM_STG] = rsp_ready;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_STG; gi++) begin : g_rdy
            assign rdy[gi] = !v_reg[gi] || rdy[gi+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[STG_PREP])
            begin
                v_reg[STG_PREP] <= req_valid;
            end
            for (int i = STG_PREP + 1; i < NUM_STG; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign req_ready = rdy[STG_PREP];
    assign rsp_valid = v_reg[STG_OUT];

    // ------------------------------------------------------------------
    // Stage 0: magnitudes, special cases, results of all but the mul and div/mod operations
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    logic [DATA_WIDTH-1:0] sum;
    logic [DATA_WIDTH-1:0] diff;
    logic                  a_neg;
    logic                  b_neg;
    logic                  a_min;
    logic                  b_zero;
    logic                  b_m1;
    logic                  a_lt_b;
    logic                  b_lt_a;
    alu_stage_t            prep_next;
    alu_stage_t            prep_reg;

    always_comb
    begin
        op_a   = req.operand_a;
        op_b   = req.operand_b;
        a_neg  = op_a[DATA_WIDTH-1];
        b_neg  = op_b[DATA_WIDTH-1];
        sum    = op_a + op_b;
        diff   = op_a - op_b;
        a_min  = (op_a == SIGN_BIT);
        b_zero = (op_b == '0);
        b_m1   = &op_b;
        a_lt_b = $signed(op_a) < $signed(op_b);
        b_lt_a = $signed(op_b) < $signed(op_a);

        prep_next.func = req.func;
        prep_next.na   = a_neg;
        prep_next.nb   = b_neg;
        // |MIN| wraps to the sign bit pattern, which is right as unsigned
        prep_next.quo  = a_neg ? (DATA_WIDTH'(0) - op_a) : op_a;
        prep_next.mb   = b_neg ? (DATA_WIDTH'(0) - op_b) : op_b;
        prep_next.rem  = '0;
        prep_next.res  = '0;
        prep_next.st   = ST_OK;

        unique case (req.func)
            FN_ADD:
            begin
                prep_next.res = sum;
                if (a_neg == b_neg && sum[DATA_WIDTH-1] != a_neg)
                    prep_next.st = ST_OVF;
            end
            FN_SUB:
            begin
                prep_next.res = diff;
                if (a_neg != b_neg && diff[DATA_WIDTH-1] != a_neg)
                    prep_next.st = ST_OVF;
            end
            FN_DIV, FN_MOD:
            begin
                if (b_zero)
                    prep_next.st = ST_DIV0;
                else if (a_min && b_m1)
                    prep_next.st = ST_OVF;
            end
            FN_NEG:
            begin
                prep_next.res = DATA_WIDTH'(0) - op_a;
                if (a_min)
                    prep_next.st = ST_OVF;
            end
            FN_AND: prep_next.res = op_a & op_b;
            FN_OR:  prep_next.res = op_a | op_b;
            FN_XOR: prep_next.res = op_a ^ op_b;
            FN_NOT: prep_next.res = ~op_a;
            FN_LT:  prep_next.res = DATA_WIDTH'(a_lt_b);
            FN_GT:  prep_next.res = DATA_WIDTH'(b_lt_a);
            FN_EQ:  prep_next.res = DATA_WIDTH'(op_a == op_b);
            FN_NE:  prep_next.res = DATA_WIDTH'(op_a != op_b);
            default: ;  // mul finishes later; unused codes give 0, ok
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[STG_PREP] && req_valid)
            prep_reg <= prep_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: unsigned magnitude product
    // ------------------------------------------------------------------
    alu_stage_t              mul_reg;
    logic [2*DATA_WIDTH-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[STG_MUL] && v_reg[STG_PREP])
        begin
            mul_reg  <= prep_reg;
            prod_reg <= (2*DATA_WIDTH)'(prep_reg.quo) * (2*DATA_WIDTH)'(prep_reg.mb);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: multiply range check and sign; feeds the divider chain
    // ------------------------------------------------------------------
    logic                  mul_sneg;
    logic [DATA_WIDTH-1:0] mul_lim;
    logic [DATA_WIDTH-1:0] prod_lo;
    logic                  mul_ovf;
    alu_stage_t            chk_next;
    alu_stage_t            div_reg [0:DATA_WIDTH];

    always_comb
    begin
        mul_sneg = mul_reg.na ^ mul_reg.nb;
        // a negative product may reach MIN, a positive one only MAX
        mul_lim  = mul_sneg ? SIGN_BIT : POS_MAX;
        prod_lo  = prod_reg[DATA_WIDTH-1:0];
        mul_ovf  = (prod_reg[2*DATA_WIDTH-1:DATA_WIDTH] != '0) || (prod_lo > mul_lim);
        chk_next = mul_reg;
        if (mul_reg.func == FN_MUL)
        begin
            chk_next.res = mul_ovf ? '0 : (mul_sneg ? (DATA_WIDTH'(0) - prod_lo) : prod_lo);
            chk_next.st  = mul_ovf ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[STG_DIV0] && v_reg[STG_MUL])
            div_reg[0] <= chk_next;
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    generate
        for (gi = 0; gi < DATA_WIDTH; gi++) begin : g_div
            logic [DATA_WIDTH:0] trial;
            logic                fits;
            alu_stage_t          step_next;

            always_comb
            begin
                trial     = {div_reg[gi].rem, div_reg[gi].quo[DATA_WIDTH-1]}
                            - {1'b0, div_reg[gi].mb};
                fits      = !trial[DATA_WIDTH];
                step_next = div_reg[gi];
                step_next.rem = fits ? trial[DATA_WIDTH-1:0]
                              : {div_reg[gi].rem[DATA_WIDTH-2:0],
                                 div_reg[gi].quo[DATA_WIDTH-1]};
                step_next.quo = {div_reg[gi].quo[DATA_WIDTH-2:0], fits};
            end

            always_ff @(posedge clk)
            begin
                if (rdy[STG_DIV0+gi+1] && v_reg[STG_DIV0+gi])
                    div_reg[gi+1] <= step_next;
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output stage: quotient/remainder signs, zero on error
    // ------------------------------------------------------------------
    alu_stage_t            fin;
    logic [DATA_WIDTH-1:0] fin_val;
    alu_rsp_t              rsp_next;
    alu_rsp_t              rsp_reg;

    always_comb
    begin
        fin = div_reg[DATA_WIDTH];
        unique case (fin.func)
            FN_DIV:  fin_val = (fin.na ^ fin.nb) ? (DATA_WIDTH'(0) - fin.quo) : fin.quo;
            FN_MOD:  fin_val = fin.na ? (DATA_WIDTH'(0) - fin.rem) : fin.rem;
            default: fin_val = fin.res;
        endcase
        rsp_next.result_value = (fin.st == ST_OK) ? fin_val : '0;
        rsp_next.status       = fin.st;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[STG_OUT] && v_reg[STG_OUT-1])
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    // input only stalls when every stage is full and the output is held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (&v_reg) && !rsp_ready)
        else $error("req_ready low with room in the pipeline");

    // errors always come with a zero result
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.result_value == '0)
        else $error("nonzero result on error status");

    // a divide leaving the chain with ok status had a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STG_OUT-1] && fin.st == ST_OK && (fin.func == FN_DIV || fin.func == FN_MOD)
        |-> fin.mb != '0)
        else $error("divide by zero not flagged");

    // an accepted beat lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> v_reg[STG_PREP])
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for checked_integer_alu
// Drives request beats (a directed table, then random operations with weighted operands)
// with random idle cycles and backpressure, predicts each response not typed into the
// table from the operation's exact value in 64 bits, and checks responses in order.
// ----------------------------------------------------------------------------
module testbench;
    import cia_pkg::*;

    // operand corner values at the block's width
    localparam logic [DATA_WIDTH-1:0] W_MIN  = SIGN_BIT;
    localparam logic [DATA_WIDTH-1:0] W_MAX  = POS_MAX;
    localparam logic [DATA_WIDTH-1:0] W_NEG1 = '1;
    localparam logic [DATA_WIDTH-1:0] W_ZERO = '0;
    localparam logic [DATA_WIDTH-1:0] W_ONE  = DATA_WIDTH'(1);

    // unused opcodes; the block must return zero with an ok status
    localparam logic [3:0] FN_SPARE0 = 4'd14;
    localparam logic [3:0] FN_SPARE1 = 4'd15;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 1850;
    // responses may still trail the last expected one by a full pipe
    localparam int TAIL_CYCLES = NUM_STG + 8;
    localparam int REPORT_CAP  = 20;

    // one directed row: the beat, and its typed-in response where it is
    // obvious (errors and extremes); otherwise the predictor decides
    typedef struct packed {
        alu_req_t req;
        logic     fixed;
        alu_rsp_t want;
    } stim_row_t;

    // an accepted beat and the response it must produce
    typedef struct packed {
        alu_req_t req;
        alu_rsp_t rsp;
    } alu_txn_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    alu_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    alu_rsp_t rsp;

    // set during a stretch of the run where neither side idles
    bit       calm = 1'b0;

    alu_txn_t  inflight_q[$];
    stim_row_t stim_table[N_DIRECTED];
    int        mismatch_count = 0;
    int        beats_accepted = 0;
    int        op_count[16];
    int        status_count[4];

    checked_integer_alu i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Response predictor. Operands are widened to 64 bits, where add, sub,
    // mul and div are all exact; the result is then range-checked against
    // the signed word. Division truncates toward zero and the remainder
    // follows the dividend's sign, as SV does for signed longint.
    // ------------------------------------------------------------------------
    function automatic alu_rsp_t alu_expected(input alu_req_t r);
        longint   sa;
        longint   sb;
        longint   exact;
        longint   lim_hi;
        longint   lim_lo;
        status_t  st;
        alu_rsp_t p;
        sa     = longint'(r.operand_a);
        sb     = longint'(r.operand_b);
        lim_hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        lim_lo = -(longint'(1) <<< (DATA_WIDTH - 1));
        exact  = 0;
        st     = ST_OK;
        case (r.func)
            FN_ADD: exact = sa + sb;
            FN_SUB: exact = sa - sb;
            FN_MUL: exact = sa * sb;
            FN_DIV, FN_MOD:
            begin
                if (sb == 0)
                    st = ST_DIV0;
                else if (sa == lim_lo && sb == -1)
                    st = ST_OVF;   // quotient 2^(N-1) does not fit; mod follows div
                else if (r.func == FN_DIV)
                    exact = sa / sb;
                else
                    exact = sa % sb;
            end
            FN_NEG: exact = -sa;
            FN_AND: exact = sa & sb;
            FN_OR:  exact = sa | sb;
            FN_XOR: exact = sa ^ sb;
            FN_NOT: exact = ~sa;
            FN_LT:  exact = (sa < sb) ? 1 : 0;
            FN_GT:  exact = (sa > sb) ? 1 : 0;
            FN_EQ:  exact = (sa == sb) ? 1 : 0;
            FN_NE:  exact = (sa != sb) ? 1 : 0;
            default: exact = 0;
        endcase
        if (st == ST_OK && (exact > lim_hi || exact < lim_lo))
            st = ST_OVF;
        p.status       = st;
        p.result_value = (st == ST_OK) ? exact[DATA_WIDTH-1:0] : '0;
        return p;
    endfunction

    function automatic stim_row_t mk_row(input logic [3:0] fn,
                                         input logic [DATA_WIDTH-1:0] a,
                                         input logic [DATA_WIDTH-1:0] b,
                                         input logic fixed,
                                         input logic [DATA_WIDTH-1:0] val,
                                         input status_t st);
        stim_row_t row;
        row.req.func          = fn;
        row.req.operand_a     = a;
        row.req.operand_b     = b;
        row.fixed             = fixed;
        row.want.result_value = val;
        row.want.status       = st;
        return row;
    endfunction

    // operand mix: corners, small values (mul/div in range), 17-bit signed values
    // (products near the overflow edge), and full-width random words
    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0: v = W_MIN;
            1: v = W_MAX;
            2:
            begin
                case ($urandom_range(0, 2))
                    0: v = W_ZERO;
                    1: v = W_ONE;
                    default: v = W_NEG1;
                endcase
            end
            3, 4: v = DATA_WIDTH'($urandom_range(0, 200)) - DATA_WIDTH'(100);
            5: v = DATA_WIDTH'($urandom_range(0, 131071)) - DATA_WIDTH'(65536);
            default: v = DATA_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    function automatic alu_req_t random_request();
        alu_req_t r;
        r.func      = 4'($urandom_range(0, 15));
        r.operand_a = pick_operand();
        r.operand_b = pick_operand();
        // now and then force the most-negative-by-minus-one corner
        if ($urandom_range(0, 19) == 0)
        begin
            r.operand_a = W_MIN;
            r.operand_b = W_NEG1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // present one beat, idling first at random; the expectation is queued
    // at the edge where the beat is taken
    task automatic send_beat(input alu_req_t r, input logic fixed, input alu_rsp_t want);
        alu_txn_t t;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        t.req = r;
        t.rsp = fixed ? want : alu_expected(r);
        inflight_q.push_back(t);
        beats_accepted++;
        op_count[r.func]++;
        status_count[t.rsp.status]++;
    endtask

    // drop valid and hold off until every outstanding beat has come back
    task automatic drain_pipeline();
        req_valid <= 1'b0;
        while (inflight_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Response side: compare each taken beat with the oldest expectation,
    // then pick rsp_ready for the next cycle.
    // ------------------------------------------------------------------------
    initial
    begin
        alu_txn_t exp_txn;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (inflight_q.size() == 0)
                    report_mismatch($sformatf("response with nothing pending: value %0d status %0d",
                                              rsp.result_value, rsp.status));
                else
                begin
                    exp_txn = inflight_q.pop_front();
                    if (rsp.result_value !== exp_txn.rsp.result_value)
                        report_mismatch($sformatf(
                            "func %0d a %0d b %0d: value %0d, wanted %0d",
                            exp_txn.req.func, exp_txn.req.operand_a, exp_txn.req.operand_b,
                            rsp.result_value, exp_txn.rsp.result_value));
                    if (rsp.status !== exp_txn.rsp.status)
                        report_mismatch($sformatf(
                            "func %0d a %0d b %0d: status %0d, wanted %0d",
                            exp_txn.req.func, exp_txn.req.operand_a, exp_txn.req.operand_b,
                            rsp.status, exp_txn.rsp.status));
                end
            end
            rsp_ready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    // ------------------------------------------------------------------------
    // Request side: reset, directed table, random beats, then wind down.
    // ------------------------------------------------------------------------
    initial
    begin
        alu_req_t rnd;
        stim_table = '{
            // add/sub overflow at both ends
            mk_row(FN_ADD, W_MAX, W_ONE, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_ADD, W_MIN, W_NEG1, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_SUB, W_MIN, W_ONE, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_SUB, W_MAX, W_NEG1, 1'b1, W_ZERO, ST_OVF),
            // multiply: negative times negative and positive times positive past the top, exact minimum
            mk_row(FN_MUL, W_MIN, W_NEG1, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_MUL, -32'sd65536, -32'sd32768, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_MUL, -32'sd65536, 32'sd32768, 1'b1, W_MIN, ST_OK),
            mk_row(FN_MUL, 32'sd46341, 32'sd46341, 1'b1, W_ZERO, ST_OVF),
            // divide by zero, minimum over minus one, truncation signs
            mk_row(FN_DIV, 32'sd7, W_ZERO, 1'b1, W_ZERO, ST_DIV0),
            mk_row(FN_MOD, W_MIN, W_ZERO, 1'b1, W_ZERO, ST_DIV0),
            mk_row(FN_DIV, W_MIN, W_NEG1, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_MOD, W_MIN, W_NEG1, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_DIV, -32'sd7, 32'sd2, 1'b1, -32'sd3, ST_OK),
            mk_row(FN_MOD, -32'sd7, 32'sd2, 1'b1, W_NEG1, ST_OK),
            // negating the minimum, and the largest legal negate
            mk_row(FN_NEG, W_MIN, W_MAX, 1'b1, W_ZERO, ST_OVF),
            mk_row(FN_NEG, W_MAX, W_MIN, 1'b1, W_MIN + W_ONE, ST_OK),
            // bitwise ops
            mk_row(FN_AND, W_MIN, 32'h5a5a_a5a5, 1'b0, W_ZERO, ST_OK),
            mk_row(FN_OR, 32'h0f0f_00ff, W_MIN, 1'b0, W_ZERO, ST_OK),
            mk_row(FN_XOR, W_NEG1, W_MAX, 1'b1, W_MIN, ST_OK),
            mk_row(FN_NOT, W_ZERO, W_NEG1, 1'b1, W_NEG1, ST_OK),
            // compares across the sign boundary
            mk_row(FN_LT, W_MIN, W_MAX, 1'b1, W_ONE, ST_OK),
            mk_row(FN_GT, W_MIN, W_MAX, 1'b1, W_ZERO, ST_OK),
            mk_row(FN_EQ, W_NEG1, W_NEG1, 1'b1, W_ONE, ST_OK),
            mk_row(FN_NE, W_MAX, W_MIN, 1'b1, W_ONE, ST_OK),
            // unused opcode returns zero, ok
            mk_row(FN_SPARE0, W_MAX, W_MAX, 1'b1, W_ZERO, ST_OK)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_beat(stim_table[i].req, stim_table[i].fixed, stim_table[i].want);
        // other spare opcode, predicted
        rnd = random_request();
        rnd.func = FN_SPARE1;
        send_beat(rnd, 1'b0, '0);
        drain_pipeline();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // full stop twice, so a fresh burst enters an empty pipe
            if (n == 600 || n == 1400)
                drain_pipeline();
            calm = (n >= 900 && n < 1150);
            send_beat(random_request(), 1'b0, '0);
        end
        calm = 1'b0;
        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d beats: add %0d sub %0d mul %0d div %0d mod %0d neg %0d, others %0d",
                 beats_accepted, op_count[FN_ADD], op_count[FN_SUB], op_count[FN_MUL],
                 op_count[FN_DIV], op_count[FN_MOD], op_count[FN_NEG],
                 beats_accepted - op_count[FN_ADD] - op_count[FN_SUB] - op_count[FN_MUL]
                 - op_count[FN_DIV] - op_count[FN_MOD] - op_count[FN_NEG]);
        $display("Statuses expected: ok %0d, overflow %0d, divide by zero %0d; errors %0d",
                 status_count[ST_OK], status_count[ST_OVF], status_count[ST_DIV0],
                 mismatch_count);
        if (mismatch_count == 0 && inflight_q.size() == 0)
            $display("checked_integer_alu: match");
        else
            $display("checked_integer_alu: mismatch");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("checked_integer_alu: mismatch");
        $finish;
    end

endmodule
